[hdl/modular_exponentiation_macros.svh]
// Assertion shorthands shared by the modular exponentiation RTL.
// Needs signals clk and rst_n in the scope of each use.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define MEXP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define MEXP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition holds at every edge out of reset
`define MEXP_ASSERT_ALW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

[hdl/mexp_pkg.sv]
// Shared types and constants for the modular exponentiation block.
// No dependencies.
package mexp_pkg;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = 2'd1;

  // status of the shared modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

[hdl/mexp_mulmod.sv]
// Bit-serial modular multiplier: r = (x * y) mod m, one bit of y per cycle.
// Depends on mexp_pkg and modular_exponentiation_macros.svh.
`include "modular_exponentiation_macros.svh"
module mexp_mulmod #(
  parameter int WORD_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start_i,
  input  logic [WORD_BITS-1:0]   x_i,     // must be below m_i
  input  logic [WORD_BITS-1:0]   y_i,
  input  logic [WORD_BITS-1:0]   m_i,     // held stable while busy
  output logic [WORD_BITS-1:0]   res_o,
  output mexp_pkg::mm_stat_t     stat_o
);
  import mexp_pkg::*;

  localparam int CNT_BITS = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] r_r, x_r, y_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic                 busy_r, done_r;

  logic [WORD_BITS:0]   m_ext, dbl, dbl_red, sum, sum_red;
  logic [WORD_BITS-1:0] step;

  // r <- 2r mod m, then r <- r + x mod m when the current bit of y is set
  always_comb begin
    m_ext   = {1'b0, m_i};
    dbl     = {r_r, 1'b0};
    dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    sum     = {1'b0, dbl_red[WORD_BITS-1:0]} + {1'b0, x_r};
    sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
    step    = y_r[WORD_BITS-1] ? sum_red[WORD_BITS-1:0] : dbl_red[WORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(WORD_BITS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      r_r <= '0;
      x_r <= x_i;
      y_r <= y_i;
    end else if (busy_r) begin
      r_r <= step;
      y_r <= {y_r[WORD_BITS-2:0], 1'b0};
    end
  end

  assign res_o       = r_r;
  assign stat_o.busy = busy_r;
  assign stat_o.done = done_r;

  `MEXP_ASSERT_IMP(a_no_restart, start_i, !busy_r, "multiplier started while busy")
  `MEXP_ASSERT_IMP(a_res_reduced, done_r, r_r < m_i, "product not reduced below modulus")
  `MEXP_ASSERT_NXT(a_done_follows, busy_r && (cnt_r == '0), done_r && !busy_r,
                   "last bit not followed by done")

endmodule

[hdl/modular_exponentiation.sv]
// Modular exponentiation, right-to-left square and multiply, top level.
// Depends on mexp_pkg, mexp_mulmod and modular_exponentiation_macros.svh.
//
// Each input word carries a base; the block returns base ** exponent mod modulus,
// with exponent and modulus set beforehand through the cfg_ port (index 0 is the
// exponent, reset 0; index 1 is the modulus, reset 1; a zero written to the
// modulus is dropped and other indexes are ignored; cfg_ready is always high).
// A zero exponent gives 1 whatever the modulus; otherwise a modulus of 1 gives 0.
// One item at a time: in_ready is high only while the sequencer is idle. All the
// arithmetic runs through one bit-serial modular multiplier that handles one bit
// of the multiplier operand a cycle. An item costs one product to reduce the base,
// then one square for each exponent bit below the top set bit and one multiply per
// set bit. With L the bit length of the exponent and P its number of set bits that
// is L + P products, or the reduction alone for a zero exponent. The in_ready flag
// rises again in the same cycle as out_valid.
// The result sits in an output register, so the next base can be taken while it
// waits; the sequencer only stalls at the end of an item if the previous result
// is still unclaimed.
`include "modular_exponentiation_macros.svh"
module modular_exponentiation #(
  parameter int WORD_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mexp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [WORD_BITS-1:0]                  cfg_data,
  // input words
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [WORD_BITS-1:0]                  in_base_value,
  // result words
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [WORD_BITS-1:0]                  out_power_result
);
  import mexp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REDUCE = 5'b00010,  // base mod m, as base * 1 through the multiplier
    ST_MULT   = 5'b00100,  // acc * p
    ST_SQUARE = 5'b01000,  // p * p
    ST_FIN    = 5'b10000   // hand result to the output register
  } state_t;

  state_t               state_r, state_nxt;
  logic [WORD_BITS-1:0] exponent_r, modulus_r;
  logic [WORD_BITS-1:0] e_r, e_nxt;        // remaining exponent bits
  logic [WORD_BITS-1:0] acc_r, acc_nxt;    // running result
  logic [WORD_BITS-1:0] p_r, p_nxt;        // current base power
  logic                 zero_exp_r, zero_exp_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] out_data_r, out_data_nxt;

  logic                 mm_start;
  logic [WORD_BITS-1:0] mm_x, mm_y, mm_res;
  mm_stat_t             mm_stat;
  logic [WORD_BITS-1:0] one_mod;           // 1 mod m

  // ---- configuration registers ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= '0;
      modulus_r  <= WORD_BITS'(1);
    end else if (cfg_valid) begin
      if (cfg_index == REG_EXPONENT) begin
        exponent_r <= cfg_data;
      end
      if ((cfg_index == REG_MODULUS) && (cfg_data != '0)) begin
        modulus_r <= cfg_data;
      end
    end
  end

  assign one_mod = {{(WORD_BITS-1){1'b0}}, (modulus_r != WORD_BITS'(1))};

  // ---- shared multiplier ----
  mexp_mulmod #(
    .WORD_BITS (WORD_BITS)
  ) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mm_start),
    .x_i     (mm_x),
    .y_i     (mm_y),
    .m_i     (modulus_r),
    .res_o   (mm_res),
    .stat_o  (mm_stat)
  );

  // ---- sequencer ----
  // Exponent scanned LSB first; the square after the top bit is skipped.
  always_comb begin
    state_nxt     = state_r;
    e_nxt         = e_r;
    acc_nxt       = acc_r;
    p_nxt         = p_r;
    zero_exp_nxt  = zero_exp_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mm_start      = 1'b0;
    mm_x          = acc_r;
    mm_y          = p_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mm_start     = 1'b1;
          mm_x         = one_mod;
          mm_y         = in_base_value;
          e_nxt        = exponent_r;
          acc_nxt      = one_mod;
          zero_exp_nxt = (exponent_r == '0);
          state_nxt    = ST_REDUCE;
        end
      end
      ST_REDUCE, ST_SQUARE: begin
        if (mm_stat.done) begin
          p_nxt = mm_res;
          if (e_r == '0) begin
            state_nxt = ST_FIN;
          end else if (e_r[0]) begin
            mm_start  = 1'b1;
            mm_x      = acc_r;
            mm_y      = mm_res;
            state_nxt = ST_MULT;
          end else begin
            // bit clear: shift and square again (remaining bits still nonzero)
            mm_start  = 1'b1;
            mm_x      = mm_res;
            mm_y      = mm_res;
            e_nxt     = {1'b0, e_r[WORD_BITS-1:1]};
            state_nxt = ST_SQUARE;
          end
        end
      end
      ST_MULT: begin
        if (mm_stat.done) begin
          acc_nxt = mm_res;
          e_nxt   = {1'b0, e_r[WORD_BITS-1:1]};
          if (e_r[WORD_BITS-1:1] == '0) begin
            state_nxt = ST_FIN;
          end else begin
            mm_start  = 1'b1;
            mm_x      = p_r;
            mm_y      = p_r;
            state_nxt = ST_SQUARE;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = zero_exp_r ? WORD_BITS'(1) : acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r        <= e_nxt;
    acc_r      <= acc_nxt;
    p_r        <= p_nxt;
    zero_exp_r <= zero_exp_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_power_result = out_data_r;

  `MEXP_ASSERT_ALW(a_modulus_nonzero, modulus_r != '0, "modulus register holds zero")
  `MEXP_ASSERT_NXT(a_accept_starts, in_valid && in_ready, state_r == ST_REDUCE,
                   "accepted word did not start base reduction")
  `MEXP_ASSERT_IMP(a_p_reduced, (state_r == ST_MULT) || (state_r == ST_SQUARE),
                   p_r < modulus_r, "base power not below modulus")
  `MEXP_ASSERT_IMP(a_acc_reduced, state_r != ST_IDLE, acc_r < modulus_r,
                   "running result not below modulus")

endmodule

[sim/tb_top.sv]
// Self-checking testbench for modular_exponentiation: base words in, powers out.
// Needs mexp_pkg and the modular_exponentiation RTL; results checked against a local
// square-and-multiply predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mexp_pkg::*;

  localparam int WORD_BITS = 32;
  localparam int RUN_LIMIT = 4_000_000;  // cycles, far beyond the slowest clean run
  localparam int TAIL_CYCLES = 2200;     // cycles of quiet wait after the final drain

  // indexes the block must ignore
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_3 = 2'd3;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [WORD_BITS-1:0]    cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [WORD_BITS-1:0]    in_base_value;
  logic                    out_valid;
  logic                    out_ready;
  logic [WORD_BITS-1:0]    out_power_result;

  // shadow copies of the two registers, updated on accepted cfg words
  logic [WORD_BITS-1:0] exponent_reg;
  logic [WORD_BITS-1:0] modulus_reg;

  logic [WORD_BITS-1:0] expected_powers[$];
  int                   error_count = 0;
  int                   cycle_count = 0;
  bit                   idle_off = 1'b0;  // set for the closing stretch: no gaps, no stalls

  modular_exponentiation #(.WORD_BITS(WORD_BITS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_base_value    (in_base_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_power_result (out_power_result)
  );

  always #2 clk = ~clk;

  // Right-to-left square and multiply. Products of two reduced words fit in 64 bits,
  // so plain modulo on the double-width value is exact. A zero exponent skips the
  // loop and leaves 1 unreduced, which is what the block returns even for modulus 1.
  function automatic logic [WORD_BITS-1:0] power_mod(input logic [WORD_BITS-1:0] base);
    logic [63:0]          m;
    logic [63:0]          sq;
    logic [63:0]          acc;
    logic [WORD_BITS-1:0] e;
    m   = 64'(modulus_reg);
    sq  = base % m;
    acc = 64'd1;
    e   = exponent_reg;
    while (e != 0) begin
      if (e[0]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
      e  = e >> 1;
    end
    return acc[WORD_BITS-1:0];
  endfunction

  // Register shadow: zero to the modulus is dropped, spare indexes do nothing.
  always @(posedge clk) begin
    if (!rst_n) begin
      exponent_reg <= '0;
      modulus_reg  <= WORD_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_EXPONENT) begin
        exponent_reg <= cfg_data;
      end else if (cfg_index == REG_MODULUS && cfg_data != 0) begin
        modulus_reg <= cfg_data;
      end
    end
  end

  // One expected power per accepted base word. Config only moves while idle, so
  // the shadow registers are stable here.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_powers = {expected_powers, power_mod(in_base_value)};
    end
  end

  // Result check against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_powers.size() == 0) begin
        $error("power_result: expected none, actual %h", out_power_result);
        error_count++;
      end else begin
        if (out_power_result !== expected_powers[0]) begin
          $error("power_result: expected %h, actual %h", expected_powers[0],
                 out_power_result);
          error_count++;
        end
        void'(expected_powers.pop_front());
      end
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("** modular_exponentiation: FAILED **");
      $finish;
    end
  end

  // Receiver: random stall bursts, with clean stretches in between.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!idle_off && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else if ($urandom_range(0, 15) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 200)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Drop in_valid and wait until every outstanding power has come back. The first
  // edge lets the accept monitor record the last word's expectation.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (expected_powers.size() == 0);
  endtask

  // Send one base word; an optional random gap goes before it, so the word
  // after an accept can follow at once without valid dropping.
  task automatic send_base(input logic [WORD_BITS-1:0] base);
    if (!idle_off && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_base_value <= base;
    do @(posedge clk); while (!in_ready);
  endtask

  // Register write, only once the block has gone idle.
  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [WORD_BITS-1:0] data);
    hold_until_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Reset values: exponent 0 and modulus 1 give 1 for any base.
  task automatic test_after_reset();
    send_base('0);
    send_base('1);
    send_base(32'h5A5A_5A5A);
  endtask

  // A zero modulus write and the spare indexes must leave both registers alone.
  task automatic test_register_writes();
    write_register(REG_EXPONENT, 32'd3);
    write_register(REG_MODULUS, 32'd1000);
    write_register(REG_MODULUS, '0);
    write_register(REG_SPARE_2, 32'd7);
    write_register(REG_SPARE_3, '1);
    send_base(32'd12345);
    send_base(32'd999);
  endtask

  task automatic test_special_cases();
    // zero exponent, ordinary modulus
    write_register(REG_EXPONENT, '0);
    send_base(32'd77);
    // zero exponent with modulus 1 still gives 1
    write_register(REG_MODULUS, 32'd1);
    send_base(32'd5);
    // nonzero exponent with modulus 1 gives 0
    write_register(REG_EXPONENT, 32'd1);
    send_base('1);
    // all-ones exponent and modulus; bases at and below the modulus
    write_register(REG_EXPONENT, '1);
    write_register(REG_MODULUS, '1);
    send_base('0);
    send_base(32'd1);
    send_base(32'hFFFF_FFFE);
    send_base('1);
    // largest 32-bit prime, Fermat exponent; a base equal to it reduces to zero
    write_register(REG_MODULUS, 32'hFFFF_FFFB);
    write_register(REG_EXPONENT, 32'hFFFF_FFFA);
    send_base(32'd2);
    send_base('1);
    send_base(32'hFFFF_FFFB);
    // lone top exponent bit, power-of-two modulus
    write_register(REG_EXPONENT, 32'h8000_0000);
    write_register(REG_MODULUS, 32'h8000_0000);
    send_base(32'd3);
    send_base(32'h8000_0001);
    // base well above the modulus gets reduced first
    write_register(REG_EXPONENT, 32'd1);
    write_register(REG_MODULUS, 32'd1000);
    send_base('1);
  endtask

  // Random settings per phase, random bases with the edges around the modulus mixed in.
  task automatic test_random_traffic(input int phases, input int words_per_phase);
    logic [WORD_BITS-1:0] exp_val;
    logic [WORD_BITS-1:0] mod_val;
    logic [WORD_BITS-1:0] base;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 5))
        0:       exp_val = '0;
        1:       exp_val = 32'd1;
        2:       exp_val = '1;
        3:       exp_val = $urandom_range(2, 255);
        default: exp_val = $urandom();
      endcase
      case ($urandom_range(0, 5))
        0:       mod_val = 32'd1;
        1:       mod_val = '1;
        2:       mod_val = $urandom_range(2, 65535);
        3:       mod_val = 32'd1 << $urandom_range(1, 31);
        default: mod_val = $urandom();
      endcase
      write_register(REG_EXPONENT, exp_val);
      write_register(REG_MODULUS, mod_val);
      // now and then some writes that must change nothing
      if ($urandom_range(0, 2) == 0) begin
        write_register(REG_MODULUS, '0);
        write_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, $urandom());
      end
      for (int i = 0; i < words_per_phase; i++) begin
        case ($urandom_range(0, 7))
          0:       base = '0;
          1:       base = '1;
          2:       base = modulus_reg - 1;
          3:       base = modulus_reg;
          4:       base = modulus_reg + 1;
          default: base = $urandom();
        endcase
        send_base(base);
      end
    end
  endtask

  // Sender waits out every result before each word.
  task automatic test_drained_words();
    write_register(REG_EXPONENT, $urandom());
    write_register(REG_MODULUS, $urandom() | 32'd1);
    for (int i = 0; i < 10; i++) begin
      hold_until_drained();
      send_base($urandom());
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_EXPONENT;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_base_value <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_register_writes();
    test_special_cases();
    test_random_traffic(7, 30);
    test_drained_words();
    // closing stretch: back-to-back words, receiver always ready
    idle_off = 1'b1;
    test_random_traffic(1, 30);

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** modular_exponentiation: PASSED **");
    end else begin
      $display("** modular_exponentiation: FAILED **");
    end
    $finish;
  end

endmodule
